// ===== hw/rtl/isl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_pkg: shared types and constants of the indexed sequence list
// Word formats, command and status codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package isl_pkg;

   // longest read-out, in result words
   localparam int RSP_MAX = 16;
   // width of the read-out index
   localparam int RIW = 4;

   // command codes
   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   // status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   // controller states
   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_READ = 1'b1
   } state_type;

   // request word
   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [31:0] value;
      logic [4:0]         position;
   } req_word_type;

   // response word
   typedef struct packed {
      logic signed [31:0] item_value;
      logic [RIW-1:0]     item_index;
      logic [1:0]         status;
      logic               last;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic read_step;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic list_empty;
      logic read_last;
   } dp_status_type;

endpackage

// ===== hw/rtl/isl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_ctrl: command sequencer
// Accepts request words while idle and steps the datapath through a
// read-out, one response word per cycle.
// ----------------------------------------------------------------------------
module isl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_cmd,
   input  isl_pkg::dp_status_type dp_status,
   output logic                   busy,
   output isl_pkg::ctrl_cmd_type  ctrl_cmd
);
   import isl_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept = start && (state_ff == STATE_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (accept && (op_type'(req_cmd) == OP_READ) && !dp_status.list_empty) begin
               state_in = STATE_READ;
            end
         end
         STATE_READ: begin
            if (dp_status.read_last) begin
               state_in = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy               = 1'b0;
      ctrl_cmd.accept    = 1'b0;
      ctrl_cmd.read_step = 1'b0;
      unique case (state_ff)
         STATE_IDLE: begin
            ctrl_cmd.accept = start;
         end
         STATE_READ: begin
            busy               = 1'b1;
            ctrl_cmd.read_step = 1'b1;
         end
         default: busy = 1'b0;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   // a read-out never starts on an empty list
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_IDLE) && (state_in == STATE_READ) |-> !dp_status.list_empty)
      else $error("read-out started on empty list");

   // read-out ends right after its last step
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.read_step && dp_status.read_last |=> (state_ff == STATE_IDLE))
      else $error("read-out did not end after last word");

   // no word is accepted while stepping a read-out
   assert property (@(posedge clock) disable iff (reset)
      !(ctrl_cmd.accept && ctrl_cmd.read_step))
      else $error("accept during read-out");
`endif

endmodule

// ===== hw/rtl/isl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_datapath: list cells, entry count and response register
// Append, insert and remove shift all cells in parallel;
// read-out selects one cell per cycle by the read index.
// ----------------------------------------------------------------------------
module isl_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  isl_pkg::ctrl_cmd_type  ctrl_cmd,
   input  isl_pkg::req_word_type  req_word,
   output isl_pkg::dp_status_type dp_status,
   output logic                   rsp_strobe,
   output isl_pkg::rsp_word_type  rsp_word
);
   import isl_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam int EW = (CW > 5) ? CW : 5;

   logic signed [31:0] cell_ff [DEPTH];
   logic signed [31:0] cell_in [DEPTH];
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic [RIW-1:0]     rd_idx_ff;
   logic [RIW-1:0]     rd_idx_in;
   logic [RIW-1:0]     rd_end_ff;
   logic [RIW-1:0]     rd_end_in;
   logic               rsp_strobe_ff;
   logic               rsp_strobe_in;
   rsp_word_type       rsp_word_ff;
   rsp_word_type       rsp_word_in;

   logic [EW-1:0]      ext_count;
   logic [EW-1:0]      ext_pos;
   logic [EW-1:0]      ins_pos;
   logic               list_full;
   logic               list_empty;
   logic               read_last;
   op_type             op;
   status_type         stat;

   // list state flags
   always_comb begin
      ext_count  = EW'(count_ff);
      ext_pos    = EW'(req_word.position);
      list_full  = (count_ff == CW'(DEPTH));
      list_empty = (count_ff == '0);
      read_last  = (rd_idx_ff == rd_end_ff);
      op         = op_type'(req_word.cmd);
      ins_pos    = (op == OP_APPEND) ? ext_count : ext_pos;
   end

   assign dp_status.list_empty = list_empty;
   assign dp_status.read_last  = read_last;

   // command execution and response word
   always_comb begin
      cell_in                = cell_ff;
      count_in               = count_ff;
      rd_idx_in              = rd_idx_ff;
      rd_end_in              = rd_end_ff;
      stat                   = STAT_OK;
      rsp_strobe_in          = 1'b0;
      rsp_word_in.item_value = '0;
      rsp_word_in.item_index = '0;
      rsp_word_in.status     = STAT_OK;
      rsp_word_in.last       = 1'b1;

      if (ctrl_cmd.accept) begin
         unique case (op) inside
            OP_APPEND, OP_INSERT: begin
               rsp_strobe_in = 1'b1;
               if (list_full) begin
                  stat = STAT_FULL;
               end else if (ins_pos > ext_count) begin
                  stat = STAT_RANGE;
               end else begin
                  for (int i = 1; i < DEPTH; i++) begin
                     if (EW'(i) > ins_pos) begin
                        cell_in[i] = cell_ff[i-1];
                     end
                  end
                  for (int i = 0; i < DEPTH; i++) begin
                     if (EW'(i) == ins_pos) begin
                        cell_in[i] = req_word.value;
                     end
                  end
                  count_in = CW'(count_ff + 1'b1);
               end
            end
            OP_REMOVE: begin
               rsp_strobe_in = 1'b1;
               if (list_empty) begin
                  stat = STAT_EMPTY;
               end else if (ext_pos >= ext_count) begin
                  stat = STAT_RANGE;
               end else begin
                  for (int i = 0; i < DEPTH - 1; i++) begin
                     if (EW'(i) >= ext_pos) begin
                        cell_in[i] = cell_ff[i+1];
                     end
                  end
                  count_in = CW'(count_ff - 1'b1);
               end
            end
            OP_READ: begin
               if (list_empty) begin
                  rsp_strobe_in = 1'b1;
                  stat          = STAT_EMPTY;
               end else begin
                  rd_idx_in = '0;
                  if (ext_count >= EW'(RSP_MAX)) begin
                     rd_end_in = RIW'(RSP_MAX - 1);
                  end else begin
                     rd_end_in = RIW'(ext_count - 1'b1);
                  end
               end
            end
            default: stat = STAT_OK;
         endcase
         rsp_word_in.status = stat;
      end else if (ctrl_cmd.read_step) begin
         rsp_strobe_in          = 1'b1;
         rsp_word_in.item_value = cell_ff[IW'(rd_idx_ff)];
         rsp_word_in.item_index = rd_idx_ff;
         rsp_word_in.status     = STAT_OK;
         rsp_word_in.last       = read_last;
         rd_idx_in              = RIW'(rd_idx_ff + 1'b1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cell_ff     <= cell_in;
      rd_idx_ff   <= rd_idx_in;
      rd_end_ff   <= rd_end_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

`ifndef SYNTHESIS
   // entry count never exceeds the list depth
   assert property (@(posedge clock) disable iff (reset)
      EW'(count_ff) <= EW'(DEPTH))
      else $error("entry count above depth");

   // read-out words come back to back until the last one
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_word_ff.last |=> rsp_strobe_ff)
      else $error("gap inside read-out");

   // read index stays below the entry count
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.read_step |-> (EW'(rd_idx_ff) < ext_count))
      else $error("read index beyond list");

   // a successful append grows the list by one
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.accept && (op == OP_APPEND) && !list_full
      |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("append did not grow list");
`endif

endmodule

// ===== hw/rtl/indexed_sequence_list_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_list_core: ordered list of signed 32-bit values
// Append, insert at position, remove at position and full read-out, with
// full, out-of-range and empty status on each response word.
// ----------------------------------------------------------------------------
//
//  channel   ports                      handshake
//  -------   ------------------------   ---------------------------------
//  request   start, busy, req_word      taken when start high, busy low
//  response  rsp_strobe, rsp_word       one strobe per word, no backpressure
//
//  append, insert and remove shift all list cells in parallel, and the
//  response word is registered and shows in the cycle after acceptance.
//  read-out emits min(count, 16) words at one per cycle, paced by the read
//  index that selects one cell per cycle; busy is high meanwhile.
//  the next request may be taken in the cycle that shows a response word.
//  reset clears the entry count, response strobe and sequencer; cells are not cleared.
//  the receiver cannot stall: every response word is taken as shown.
//
module indexed_sequence_list_core #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  isl_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output isl_pkg::rsp_word_type rsp_word
);
   import isl_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // sequencer
   isl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_word.cmd),
      .dp_status (dp_status),
      .busy      (busy),
      .ctrl_cmd  (ctrl_cmd)
   );

   // cells and response register
   isl_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl_cmd   (ctrl_cmd),
      .req_word   (req_word),
      .dp_status  (dp_status),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== tb/isl_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isl_list_checker: response checker for the indexed sequence list
// Watches the request and response channels, keeps its own copy of the list
// cells and entry count, and compares every response word field by field
// against the oldest predicted word.
// ----------------------------------------------------------------------------
module isl_list_checker #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  isl_pkg::req_word_type req_word,
   input  logic                  rsp_strobe,
   input  isl_pkg::rsp_word_type rsp_word,
   output int                    mismatch_count,
   output int                    words_due
);
   import isl_pkg::*;

   // shadow list state
   logic signed [31:0] list_cells [DEPTH];
   int                 cell_count;

   // response words predicted but not yet seen
   rsp_word_type       list_rsp_due [$];

   // one line per mismatch, and count it
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // apply one accepted command to the shadow list, queue the words it causes
   task automatic apply_list_command(input req_word_type w);
      rsp_word_type r;
      status_type   st;
      int           at;
      int           n;
      r = '0;
      r.last = 1'b1;
      st = STAT_OK;
      case (op_type'(w.cmd))
         OP_APPEND, OP_INSERT: begin
            at = (op_type'(w.cmd) == OP_APPEND) ? cell_count : int'(w.position);
            // fullness wins over a bad position
            if (cell_count >= DEPTH) st = STAT_FULL;
            else if (at > cell_count) st = STAT_RANGE;
            else begin
               for (int i = cell_count; i > at; i--) list_cells[i] = list_cells[i-1];
               list_cells[at] = w.value;
               cell_count++;
            end
         end
         OP_REMOVE: begin
            if (cell_count == 0) st = STAT_EMPTY;
            else if (int'(w.position) >= cell_count) st = STAT_RANGE;
            else begin
               for (int i = int'(w.position); i + 1 < cell_count; i++)
                  list_cells[i] = list_cells[i+1];
               cell_count--;
            end
         end
         default: begin
            // read-out of at most RSP_MAX words, last one marked
            if (cell_count == 0) st = STAT_EMPTY;
            else begin
               n = (cell_count > RSP_MAX) ? RSP_MAX : cell_count;
               for (int i = 0; i < n; i++) begin
                  r.item_value = list_cells[i];
                  r.item_index = i[RIW-1:0];
                  r.status     = STAT_OK;
                  r.last       = (i == n - 1);
                  list_rsp_due.push_back(r);
               end
            end
         end
      endcase
      if (op_type'(w.cmd) != OP_READ || cell_count == 0) begin
         r.status = st;
         list_rsp_due.push_back(r);
      end
   endtask

   // compare one response word with the oldest prediction
   task automatic check_rsp_word(input rsp_word_type got);
      rsp_word_type want;
      if (list_rsp_due.size() == 0) begin
         report_mismatch("unexpected response word", {got.item_value}, '0);
      end else begin
         want = list_rsp_due.pop_front();
         if (got.item_value !== want.item_value)
            report_mismatch("item_value", got.item_value, want.item_value);
         if (got.item_index !== want.item_index)
            report_mismatch("item_index", 32'(got.item_index), 32'(want.item_index));
         if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
         if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
      end
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         cell_count = 0;
         list_rsp_due.delete();
         words_due <= 0;
      end else begin
         if (rsp_strobe === 1'b1) check_rsp_word(rsp_word);
         if (start && busy === 1'b0) apply_list_command(req_word);
         words_due <= list_rsp_due.size();
      end
   end

endmodule

// ===== tb/indexed_sequence_list_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_sequence_list_core_tb: testbench top for the indexed sequence list
// Drives a directed pass over the status corner cases, then random command
// bursts that alternately fill and drain the list, and reports the checker's
// verdict once every predicted response word has arrived.
// ----------------------------------------------------------------------------
module indexed_sequence_list_core_tb;
   import isl_pkg::*;

   localparam int DEPTH = 16;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;
   int           mismatch_count;
   int           words_due;

   // rough entry count, only used to steer the stimulus
   int           count_hint = 0;
   int           burst_left = 0;
   bit           growing = 1'b1;

   indexed_sequence_list_core #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   isl_list_checker #(.DEPTH(DEPTH)) list_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_word       (req_word),
      .rsp_strobe     (rsp_strobe),
      .rsp_word       (rsp_word),
      .mismatch_count (mismatch_count),
      .words_due      (words_due)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic req_word_type make_cmd(input op_type op, input logic [31:0] v,
                                             input logic [4:0] p);
      req_word_type w;
      w.cmd      = op;
      w.value    = v;
      w.position = p;
      return w;
   endfunction

   // present one word until taken, then idle between bursts
   task automatic send_command(input req_word_type w);
      int gap;
      @(negedge clock);
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      case (op_type'(w.cmd))
         OP_APPEND: if (count_hint < DEPTH) count_hint++;
         OP_INSERT: if (count_hint < DEPTH && w.position <= count_hint) count_hint++;
         OP_REMOVE: if (count_hint > 0 && w.position < count_hint) count_hint--;
         default: ;
      endcase
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(60, 30)
                                               : $urandom_range(12, 1);
         gap = $urandom_range(6);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
   endtask

   // random command, biased toward filling or draining the list
   task automatic send_random_command();
      req_word_type w;
      int           roll;
      roll = $urandom_range(99);
      if (roll < 14) w.cmd = OP_READ;
      else if (growing) w.cmd = (roll < 50) ? OP_APPEND : (roll < 85) ? OP_INSERT : OP_REMOVE;
      else w.cmd = (roll < 24) ? OP_APPEND : (roll < 34) ? OP_INSERT : OP_REMOVE;
      case ($urandom_range(15))
         0:       w.value = 32'h7fff_ffff;
         1:       w.value = 32'h8000_0000;
         2:       w.value = 32'h0;
         3:       w.value = 32'hffff_ffff;
         default: w.value = $urandom();
      endcase
      if ($urandom_range(9) == 0) w.position = 5'($urandom_range(31));
      else w.position = 5'($urandom_range(count_hint));
      send_command(w);
      // swing between filling and draining phases
      if (count_hint >= DEPTH && $urandom_range(3) == 0) growing = 1'b0;
      else if (count_hint == 0 && $urandom_range(1) == 0) growing = 1'b1;
      else if ($urandom_range(39) == 0) growing = ~growing;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list corners
      send_command(make_cmd(OP_READ, 32'h0, 5'd0));
      send_command(make_cmd(OP_REMOVE, 32'h0, 5'd0));
      // value extremes and position corners
      send_command(make_cmd(OP_APPEND, 32'h7fff_ffff, 5'd0));
      send_command(make_cmd(OP_APPEND, 32'h8000_0000, 5'd31));
      send_command(make_cmd(OP_INSERT, 32'hffff_ffff, 5'd0));
      send_command(make_cmd(OP_INSERT, 32'h0, 5'd3));
      send_command(make_cmd(OP_INSERT, 32'h1234_5678, 5'd5));
      send_command(make_cmd(OP_REMOVE, 32'h0, 5'd4));
      send_command(make_cmd(OP_REMOVE, 32'h0, 5'd1));
      // fill to capacity, then full list corners
      while (count_hint < DEPTH) send_command(make_cmd(OP_APPEND, $urandom(), 5'd0));
      send_command(make_cmd(OP_APPEND, 32'h5555_aaaa, 5'd0));
      send_command(make_cmd(OP_INSERT, 32'haaaa_5555, 5'd31));
      send_command(make_cmd(OP_READ, 32'h0, 5'd0));

      growing = 1'b0;
      for (int k = 0; k < 245; k++) send_random_command();

      // drain and let the last read-out settle
      @(negedge clock);
      start <= 1'b0;
      while (words_due != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
